// ----- sv/spf_pkg.sv -----
package spf_pkg;

    localparam int CW = 16;
    localparam int XW = 40;

    localparam logic [XW-1:0] X_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [XW-1:0] X_MIN = 40'h80_0000_0000;

    localparam logic [1:0] FUNC_VERTEX  = 2'd0;
    localparam logic [1:0] FUNC_BREAK   = 2'd1;
    localparam logic [1:0] FUNC_ADVANCE = 2'd2;

    typedef enum logic [1:0] {
        SW_RANGE,
        SW_COUNT,
        SW_SELECT,
        SW_STEP
    } sweep_mode_t;

    typedef struct packed {
        logic signed [CW-1:0] top;
        logic signed [CW-1:0] bottom;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] step;
    } entry_t;

    typedef struct packed {
        logic        load_in;
        logic        ack_load;
        logic        upd_prev;
        logic        clr_prev;
        logic        div_start;
        logic        edge_write;
        logic        sweep_start;
        sweep_mode_t sweep_mode;
        logic        set_scanning;
        logic        clr_scanning;
        logic        take_sel;
        logic        span_load;
        logic        noline_load;
        logic        empty_load;
        logic        line_end;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       scanning;
        logic       cnt_zero;
        logic       make_edge;
        logic       cnt_full;
        logic       div_done;
        logic       sweep_done;
        logic       can_load;
        logic       many_active;
        logic       sel_odd;
        logic       sel_last;
    } stat_t;

endpackage

// ----- sv/spf_div.sv -----
module spf_div #(
    parameter int QW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [QW-1:0] num,
    input  logic [15:0]   den,
    output logic          done,
    output logic [QW-1:0] quot
);

    localparam int CNTW = $clog2(QW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [15:0]     rem_reg;
    logic [15:0]     den_reg;
    logic [QW-1:0]   quo_reg;

    logic [16:0]     shifted;
    logic            ge;
    logic [16:0]     diff;

    // one quotient bit a cycle, restoring
    assign shifted = {rem_reg, quo_reg[QW-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(QW);
                rem_reg  <= '0;
                den_reg  <= den;
                quo_reg  <= num;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[15:0] : shifted[15:0];
                quo_reg <= {quo_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ----- sv/spf_dp.sv -----
module spf_dp #(
    parameter int MAX_EDGES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spf_pkg::cmd_t        cmd,
    output spf_pkg::stat_t       stat,
    input  logic [31:0]          in_tdata,
    input  logic [1:0]           in_tuser,
    input  logic                 out_tready,
    output logic                 out_tvalid,
    output logic [47:0]          out_tdata,
    output logic                 out_tlast,
    output logic [2:0]           out_tuser
);

    localparam int AW = $clog2(MAX_EDGES);
    localparam int NW = $clog2(MAX_EDGES + 1);
    localparam int CW = spf_pkg::CW;
    localparam int XW = spf_pkg::XW;
    localparam int QW = CW + FRAC_BITS;
    localparam logic [XW:0] MAG_MAX = {2'b00, {(XW-1){1'b1}}};
    localparam logic [XW:0] MAG_MIN = {2'b01, {(XW-1){1'b0}}};

    function automatic logic [CW-1:0] trunc16(input logic [XW-1:0] x);
        logic        neg;
        logic [XW:0] mag;
        logic [XW:0] q;
        logic [CW-1:0] r;
        neg = x[XW-1];
        mag = neg ? (~{x[XW-1], x}) + (XW+1)'(1) : {1'b0, x};
        q   = mag >> FRAC_BITS;
        if (!neg)
            r = (q > (XW+1)'(32767)) ? 16'h7FFF : q[CW-1:0];
        else
            r = (q > (XW+1)'(32768)) ? 16'h8000 : (~q[CW-1:0]) + 16'd1;
        return r;
    endfunction

    // latched item and ring state
    logic [1:0]           func_reg;
    logic signed [CW-1:0] vx_reg, vy_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;
    logic                 prev_valid_reg;
    logic [NW-1:0]        count_reg;
    logic signed [CW-1:0] scan_line_reg, scan_last_reg;
    logic                 scanning_reg;
    logic                 neg_reg;

    // sweep engine
    logic                 sw_active_reg;
    logic [NW-1:0]        sw_addr_reg;
    spf_pkg::sweep_mode_t sw_mode_reg;
    logic                 pend_reg, pend_last_reg;
    logic [AW-1:0]        pend_idx_reg;
    spf_pkg::entry_t      rd_reg;

    // selection state
    logic [NW-1:0]        n_act_reg;
    logic [NW-1:0]        sel_cnt_reg;
    logic signed [XW-1:0] best_x_reg, last_x_reg;
    logic [AW-1:0]        best_idx_reg, last_idx_reg;
    logic                 found_reg;
    logic [CW-1:0]        left_reg;

    // result register
    logic                 out_valid_reg;
    logic [CW-1:0]        out_y_reg, out_l_reg, out_r_reg;
    logic                 out_span_reg, out_last_reg, out_done_reg, out_full_reg;

    spf_pkg::entry_t      mem [MAX_EDGES];
    logic                 we;
    logic [AW-1:0]        waddr;
    spf_pkg::entry_t      wdata;

    logic signed [CW:0]   dx, dy, dxm, dym;
    logic [QW-1:0]        quot;
    logic                 div_done;
    logic [XW:0]          qmag;
    logic [XW-1:0]        step_sat;
    logic [XW:0]          qneg;
    logic signed [XW-1:0] cur_fix, prev_fix;
    spf_pkg::entry_t      new_edge;

    logic                 act, first_idx, after_last, better;
    logic [XW:0]          xsum;
    logic [XW-1:0]        x_stepped;
    logic                 done_line, make_edge, cnt_full, ack_full, can_load, sel_last;
    logic [NW-1:0]        addr_inc;

    assign dx  = {vx_reg[CW-1], vx_reg} - {prev_x_reg[CW-1], prev_x_reg};
    assign dy  = {vy_reg[CW-1], vy_reg} - {prev_y_reg[CW-1], prev_y_reg};
    assign dxm = dx[CW] ? -dx : dx;
    assign dym = dy[CW] ? -dy : dy;

    spf_div #(.QW(QW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({dxm[CW-1:0], {FRAC_BITS{1'b0}}}),
        .den   (dym[CW-1:0]),
        .done  (div_done),
        .quot  (quot)
    );

    // saturate the signed quotient to the x format
    assign qmag = (XW+1)'(quot);
    assign qneg = (~qmag) + (XW+1)'(1);
    always_comb
    begin
        if (!neg_reg)
            step_sat = (qmag > MAG_MAX) ? spf_pkg::X_MAX : qmag[XW-1:0];
        else
            step_sat = (qmag > MAG_MIN) ? spf_pkg::X_MIN : qneg[XW-1:0];
    end

    assign cur_fix  = XW'(vx_reg) <<< FRAC_BITS;
    assign prev_fix = XW'(prev_x_reg) <<< FRAC_BITS;

    always_comb
    begin
        if (prev_y_reg < vy_reg)
        begin
            new_edge.top    = prev_y_reg;
            new_edge.bottom = vy_reg;
            new_edge.x      = prev_fix;
        end
        else
        begin
            new_edge.top    = vy_reg;
            new_edge.bottom = prev_y_reg;
            new_edge.x      = cur_fix;
        end
        new_edge.step = step_sat;
    end

    assign act        = (rd_reg.top <= scan_line_reg) && (rd_reg.bottom > scan_line_reg);
    assign first_idx  = pend_idx_reg == '0;
    assign after_last = (sel_cnt_reg == '0) || (rd_reg.x > last_x_reg)
                        || ((rd_reg.x == last_x_reg) && (pend_idx_reg > last_idx_reg));
    assign better     = first_idx || !found_reg || (rd_reg.x < best_x_reg);

    assign xsum      = {rd_reg.x[XW-1], rd_reg.x} + {rd_reg.step[XW-1], rd_reg.step};
    assign x_stepped = (xsum[XW] != xsum[XW-1])
                       ? (xsum[XW] ? spf_pkg::X_MIN : spf_pkg::X_MAX) : xsum[XW-1:0];

    always_comb
    begin
        if (cmd.edge_write)
        begin
            we    = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = new_edge;
        end
        else
        begin
            we      = pend_reg && (sw_mode_reg == spf_pkg::SW_STEP) && act;
            waddr   = pend_idx_reg;
            wdata   = rd_reg;
            wdata.x = x_stepped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[sw_addr_reg[AW-1:0]];
    end

    assign done_line = scan_line_reg >= scan_last_reg;
    assign make_edge = prev_valid_reg && (prev_y_reg != vy_reg);
    assign cnt_full  = count_reg >= NW'(MAX_EDGES);
    assign ack_full  = (func_reg == spf_pkg::FUNC_VERTEX) && !scanning_reg
                       && make_edge && cnt_full;
    assign can_load  = !out_valid_reg || out_tready;
    assign sel_last  = (sel_cnt_reg + NW'(1)) == {n_act_reg[NW-1:1], 1'b0};
    assign addr_inc  = sw_addr_reg + NW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg       <= '0;
            vx_reg         <= '0;
            vy_reg         <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_valid_reg <= 1'b0;
            count_reg      <= '0;
            scan_line_reg  <= '0;
            scan_last_reg  <= '0;
            scanning_reg   <= 1'b0;
            neg_reg        <= 1'b0;
            sw_active_reg  <= 1'b0;
            sw_addr_reg    <= '0;
            sw_mode_reg    <= spf_pkg::SW_RANGE;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            pend_idx_reg   <= '0;
            n_act_reg      <= '0;
            sel_cnt_reg    <= '0;
            best_x_reg     <= '0;
            best_idx_reg   <= '0;
            last_x_reg     <= '0;
            last_idx_reg   <= '0;
            found_reg      <= 1'b0;
            left_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_y_reg      <= '0;
            out_l_reg      <= '0;
            out_r_reg      <= '0;
            out_span_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
            out_done_reg   <= 1'b0;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                func_reg <= in_tuser;
                vx_reg   <= in_tdata[15:0];
                vy_reg   <= in_tdata[31:16];
            end
            if (cmd.div_start)
                neg_reg <= dx[CW] ^ dy[CW];
            if (cmd.upd_prev)
            begin
                prev_x_reg     <= vx_reg;
                prev_y_reg     <= vy_reg;
                prev_valid_reg <= 1'b1;
            end
            if (cmd.clr_prev)
                prev_valid_reg <= 1'b0;
            if (cmd.edge_write)
                count_reg <= count_reg + NW'(1);
            if (cmd.set_scanning)
                scanning_reg <= 1'b1;
            if (cmd.clr_scanning)
                scanning_reg <= 1'b0;

            // walk the table, one entry issued per cycle
            pend_reg      <= sw_active_reg;
            pend_idx_reg  <= sw_addr_reg[AW-1:0];
            pend_last_reg <= addr_inc == count_reg;
            if (cmd.sweep_start)
            begin
                sw_active_reg <= 1'b1;
                sw_addr_reg   <= '0;
                sw_mode_reg   <= cmd.sweep_mode;
                if (cmd.sweep_mode == spf_pkg::SW_COUNT)
                    sel_cnt_reg <= '0;
            end
            else if (sw_active_reg)
            begin
                sw_addr_reg <= addr_inc;
                if (addr_inc == count_reg)
                    sw_active_reg <= 1'b0;
            end

            if (pend_reg)
            begin
                case (sw_mode_reg)
                    spf_pkg::SW_RANGE:
                    begin
                        if (first_idx || rd_reg.top < scan_line_reg)
                            scan_line_reg <= rd_reg.top;
                        if (first_idx || rd_reg.bottom > scan_last_reg)
                            scan_last_reg <= rd_reg.bottom;
                    end
                    spf_pkg::SW_COUNT:
                        n_act_reg <= (first_idx ? '0 : n_act_reg) + NW'(act);
                    spf_pkg::SW_SELECT:
                    begin
                        if (act && after_last && better)
                        begin
                            best_x_reg   <= rd_reg.x;
                            best_idx_reg <= pend_idx_reg;
                            found_reg    <= 1'b1;
                        end
                        else if (first_idx)
                            found_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end

            if (cmd.take_sel)
            begin
                last_x_reg   <= best_x_reg;
                last_idx_reg <= best_idx_reg;
                sel_cnt_reg  <= sel_cnt_reg + NW'(1);
                if (!sel_cnt_reg[0])
                    left_reg <= trunc16(best_x_reg);
            end

            if (cmd.line_end)
            begin
                if (done_line)
                begin
                    count_reg      <= '0;
                    scanning_reg   <= 1'b0;
                    prev_valid_reg <= 1'b0;
                end
                else
                    scan_line_reg <= scan_line_reg + 16'sd1;
            end

            // result register
            if (cmd.ack_load || cmd.empty_load || cmd.noline_load || cmd.span_load)
            begin
                out_valid_reg <= 1'b1;
                out_y_reg     <= (cmd.noline_load || cmd.span_load) ? scan_line_reg : '0;
                out_l_reg     <= cmd.span_load ? left_reg : '0;
                out_r_reg     <= cmd.span_load ? trunc16(best_x_reg) : '0;
                out_span_reg  <= cmd.span_load;
                out_last_reg  <= !cmd.span_load || sel_last;
                out_done_reg  <= cmd.empty_load || (cmd.noline_load && done_line)
                                 || (cmd.span_load && sel_last && done_line);
                out_full_reg  <= cmd.ack_load && ack_full;
            end
            else if (out_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.func        = func_reg;
        stat.scanning    = scanning_reg;
        stat.cnt_zero    = count_reg == '0;
        stat.make_edge   = make_edge;
        stat.cnt_full    = cnt_full;
        stat.div_done    = div_done;
        stat.sweep_done  = pend_reg && pend_last_reg;
        stat.can_load    = can_load;
        stat.many_active = n_act_reg >= NW'(2);
        stat.sel_odd     = sel_cnt_reg[0];
        stat.sel_last    = sel_last;
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = {out_r_reg, out_l_reg, out_y_reg};
    assign out_tlast  = out_last_reg;
    assign out_tuser  = {out_full_reg, out_done_reg, out_span_reg};

endmodule

// ----- sv/spf_ctrl.sv -----
module spf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_tvalid,
    output logic           in_tready,
    input  spf_pkg::stat_t stat,
    output spf_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_WRITE,
        S_ACK,
        S_EMPTY,
        S_RANGE,
        S_COUNT,
        S_PLAN,
        S_SELECT,
        S_TAKE,
        S_NOSPAN,
        S_STEP,
        S_END
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
                if (in_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            S_DECODE:
                if (stat.func == spf_pkg::FUNC_ADVANCE)
                begin
                    if (stat.cnt_zero)
                        state_next = S_EMPTY;
                    else if (!stat.scanning)
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_mode  = spf_pkg::SW_RANGE;
                        state_next      = S_RANGE;
                    end
                    else
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_mode  = spf_pkg::SW_COUNT;
                        state_next      = S_COUNT;
                    end
                end
                else if (stat.func == spf_pkg::FUNC_VERTEX && !stat.scanning
                         && stat.make_edge && !stat.cnt_full)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_ACK;
            S_DIV:
                if (stat.div_done)
                    state_next = S_WRITE;
            S_WRITE:
                if (stat.can_load)
                begin
                    cmd.edge_write = 1'b1;
                    cmd.upd_prev   = 1'b1;
                    cmd.ack_load   = 1'b1;
                    state_next     = S_IDLE;
                end
            S_ACK:
                if (stat.can_load)
                begin
                    cmd.ack_load = 1'b1;
                    cmd.upd_prev = !stat.scanning && stat.func == spf_pkg::FUNC_VERTEX;
                    cmd.clr_prev = !stat.scanning && stat.func == spf_pkg::FUNC_BREAK;
                    state_next   = S_IDLE;
                end
            S_EMPTY:
                if (stat.can_load)
                begin
                    cmd.empty_load   = 1'b1;
                    cmd.clr_scanning = 1'b1;
                    state_next       = S_IDLE;
                end
            S_RANGE:
                if (stat.sweep_done)
                begin
                    cmd.set_scanning = 1'b1;
                    cmd.sweep_start  = 1'b1;
                    cmd.sweep_mode   = spf_pkg::SW_COUNT;
                    state_next       = S_COUNT;
                end
            S_COUNT:
                if (stat.sweep_done)
                    state_next = S_PLAN;
            S_PLAN:
                if (stat.many_active)
                begin
                    cmd.sweep_start = 1'b1;
                    cmd.sweep_mode  = spf_pkg::SW_SELECT;
                    state_next      = S_SELECT;
                end
                else
                    state_next = S_NOSPAN;
            S_SELECT:
                if (stat.sweep_done)
                    state_next = S_TAKE;
            S_TAKE:
                if (!stat.sel_odd)
                begin
                    cmd.take_sel    = 1'b1;
                    cmd.sweep_start = 1'b1;
                    cmd.sweep_mode  = spf_pkg::SW_SELECT;
                    state_next      = S_SELECT;
                end
                else if (stat.can_load)
                begin
                    cmd.take_sel    = 1'b1;
                    cmd.span_load   = 1'b1;
                    cmd.sweep_start = 1'b1;
                    if (stat.sel_last)
                    begin
                        cmd.sweep_mode = spf_pkg::SW_STEP;
                        state_next     = S_STEP;
                    end
                    else
                    begin
                        cmd.sweep_mode = spf_pkg::SW_SELECT;
                        state_next     = S_SELECT;
                    end
                end
            S_NOSPAN:
                if (stat.can_load)
                begin
                    cmd.noline_load = 1'b1;
                    cmd.sweep_start = 1'b1;
                    cmd.sweep_mode  = spf_pkg::SW_STEP;
                    state_next      = S_STEP;
                end
            S_STEP:
                if (stat.sweep_done)
                    state_next = S_END;
            S_END:
            begin
                cmd.line_end = 1'b1;
                state_next   = S_IDLE;
            end
        endcase
    end

    assign in_tready = state_reg == S_IDLE;

endmodule

// ----- sv/scanline_polygon_span_fill.sv -----
// Scanline polygon span fill. Vertices stream in as beats with tuser 0; each
// pair of consecutive vertices of a ring with differing y becomes an edge
// (top, bottom, start x and slope dx/dy in signed fixed point with FRAC_BITS
// fraction bits); tuser 1 starts a new ring and no closing edge is made.
// Each tuser 2 beat renders one scanline, from the least top to the greatest
// bottom: active edges are ordered by x (table order among equal x), paired
// into spans, one span per output beat, and then stepped by their slopes.
// The beat with fill_done marks the final line, after which the table is
// empty again. Loads, breaks and unused codes return one acknowledge beat.
// Timing: one item at a time. A vertex that makes an edge waits on the
// bit-serial slope divider. A scanline walks the edge table once per pass
// at one entry a cycle through the table's single read port: one pass to
// count the active edges, one per span end selected, and one to step the
// active edges, plus one more pass on the first line to find the scan range.
module scanline_polygon_span_fill #(
    parameter int MAX_EDGES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // vertex_x, vertex_y
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // span_y, span_x_left, span_x_right
    output logic        m_axis_tlast,   // line_last
    output logic [2:0]  m_axis_tuser    // span_valid, fill_done, table_full
);

    spf_pkg::cmd_t  cmd;
    spf_pkg::stat_t stat;

    spf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spf_dp #(
        .MAX_EDGES (MAX_EDGES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_tdata   (s_axis_tdata),
        .in_tuser   (s_axis_tuser),
        .out_tready (m_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tdata  (m_axis_tdata),
        .out_tlast  (m_axis_tlast),
        .out_tuser  (m_axis_tuser)
    );

endmodule

// ----- sv/spf_checker.sv -----
module spf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [2:0]  m_axis_tuser
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // one item at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous item in flight");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("fill_done without line_last");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            !m_axis_tuser[2] && ($signed(m_axis_tdata[31:16]) <= $signed(m_axis_tdata[47:32])))
        else $error("span ends out of order");

    a_full_ack: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tlast && !m_axis_tuser[0] && !m_axis_tuser[1] && m_axis_tdata == 48'd0)
        else $error("table_full on a non-acknowledge beat");

endmodule

bind scanline_polygon_span_fill spf_checker u_spf_checker (.*);
